// ----- hw/rtl/pwavg_pkg.sv -----
// Shared types and constants for the per-index weighted average block.
package pwavg_pkg;

  localparam int unsigned DefaultEntryCount = 16;

  localparam int unsigned PriceW = 32;
  localparam int unsigned SizeW  = 24;
  localparam int unsigned SumW   = 64;
  localparam int unsigned VolW   = 40;
  localparam int unsigned CntW   = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned IdxExtW = 9;

  localparam logic [1:0] OpTrade = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpOpen  = 2'd2;
  localparam logic [1:0] OpClose = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [IdxW-1:0]          entry_index;
    logic signed [PriceW-1:0] trade_price;
    logic [SizeW-1:0]         trade_size;
  } in_item_t;

  typedef struct packed {
    logic signed [PriceW-1:0] average_price;
    logic [VolW-1:0]          total_volume;
    logic [CntW-1:0]          trade_count;
    logic                     accepted;
  } out_item_t;

  typedef struct packed {
    logic signed [SumW-1:0]   wsum;
    logic [VolW-1:0]          vol;
    logic [CntW-1:0]          cnt;
    logic signed [PriceW-1:0] avg;
  } entry_t;

endpackage

// ----- hw/rtl/per_index_weighted_average_top.sv -----
// Top level: per-index volume-weighted average price table.
//
// Holds ENTRY_COUNT accumulators (weighted sum, volume, trade count, average)
// in one RAM; reset and the open command clear every entry at once through
// per-entry valid bits. One item is worked at a time and every item yields one
// result. Query, open, close and a refused trade go from the entry read
// straight to the output register. A trade that is taken up (window open,
// index in range) runs a bit-serial signed multiply of price by size (one
// size bit per cycle), a saturating update, and a radix-2 restoring division
// of the weighted sum by the volume (one quotient bit per cycle, skipped when
// the volume is zero). The input is stalled while an item is in work; the
// output register lets a finished result wait while the next item is taken,
// and a further finished result holds the input stalled until the output
// register is free again.
module per_index_weighted_average_top #(
  parameter int unsigned ENTRY_COUNT = pwavg_pkg::DefaultEntryCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pwavg_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pwavg_pkg::out_item_t out_item_o
);

  import pwavg_pkg::*;

  localparam int unsigned AddrW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StDivI = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  localparam logic [5:0] MulSteps = 6'(SizeW);
  localparam logic [5:0] DivSteps = 6'(PriceW);

  logic [2:0]             state_q, state_d;
  logic                   win_q;
  logic [ENTRY_COUNT-1:0] vld_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   accept;
  logic [IdxExtW-1:0]     idx_ext;
  logic                   in_range;
  logic [AddrW-1:0]       in_addr;

  logic [AddrW-1:0]       addr_q;
  logic                   range_q;
  logic                   go_q;
  logic signed [PriceW-1:0] price_q;
  logic [SizeW-1:0]       sz_q;
  logic [5:0]             step_q;
  entry_t                 ent_q;
  logic [SumW-1:0]        acc_q;
  logic [VolW:0]          rem_q;
  logic [PriceW-1:0]      quo_q;
  logic                   neg_q, ovf_q, zero_q;

  entry_t                 rdata;
  entry_t                 wdata;
  logic                   ram_we;

  logic [SumW-1:0]        price_ext;
  logic [SumW:0]          sum_ext;
  logic [SumW-1:0]        sum_sat;
  logic [VolW:0]          vol_ext;
  logic [SumW-1:0]        mag;
  logic [VolW:0]          div_t;
  logic                   div_ge;
  logic                   sat;
  logic [PriceW-1:0]      avg_fin;
  logic                   out_free;

  assign accept   = in_valid_i && (state_q == StIdle);
  assign idx_ext  = IdxExtW'(in_item_i.entry_index);
  assign in_range = idx_ext < IdxExtW'(ENTRY_COUNT);
  assign in_addr  = idx_ext[AddrW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign price_ext = {{(SumW-PriceW){price_q[PriceW-1]}}, price_q};
  assign sum_ext   = {ent_q.wsum[SumW-1], ent_q.wsum} + {acc_q[SumW-1], acc_q};
  always_comb begin
    sum_sat = sum_ext[SumW-1:0];
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
  end
  assign vol_ext = {1'b0, ent_q.vol} + (VolW+1)'(sz_q);
  assign mag     = ent_q.wsum[SumW-1] ? (~ent_q.wsum + 64'd1) : ent_q.wsum;
  assign div_t   = {rem_q[VolW-1:0], acc_q[SumW-1]};
  assign div_ge  = div_t >= {1'b0, ent_q.vol};

  assign sat = ovf_q || quo_q[PriceW-1];
  always_comb begin
    if (zero_q) begin
      avg_fin = '0;
    end else if (neg_q) begin
      avg_fin = sat ? {1'b1, {(PriceW-1){1'b0}}} : (~quo_q + 32'd1);
    end else begin
      avg_fin = sat ? {1'b0, {(PriceW-1){1'b1}}} : quo_q;
    end
  end

  always_comb begin
    wdata     = ent_q;
    wdata.avg = avg_fin;
  end
  assign ram_we = (state_q == StFin);

  pwavg_ram #(
    .Width ($bits(entry_t)),
    .Depth (ENTRY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StRead;
      StRead: state_d = go_q ? StMul : StOut;
      StMul:  if (step_q == MulSteps - 6'd1) state_d = StAdd;
      StAdd:  state_d = StDivI;
      StDivI: state_d = (ent_q.vol == '0) ? StFin : StDiv;
      StDiv:  if (step_q == DivSteps - 6'd1) state_d = StFin;
      StFin:  state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      win_q       <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_item_i.opcode == OpOpen) begin
        win_q <= 1'b1;
        vld_q <= '0;
      end else if (accept && in_item_i.opcode == OpClose) begin
        win_q <= 1'b0;
      end
      if (state_q == StFin) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          addr_q  <= in_addr;
          range_q <= in_range;
          go_q    <= (in_item_i.opcode == OpTrade) && win_q && in_range;
          price_q <= in_item_i.trade_price;
          sz_q    <= in_item_i.trade_size;
        end
      end
      StRead: begin
        ent_q  <= (range_q && vld_q[addr_q]) ? rdata : '0;
        acc_q  <= '0;
        step_q <= '0;
      end
      StMul: begin
        acc_q  <= {acc_q[SumW-2:0], 1'b0} + (sz_q[SizeW-1] ? price_ext : '0);
        sz_q   <= {sz_q[SizeW-2:0], sz_q[SizeW-1]};
        step_q <= step_q + 6'd1;
      end
      StAdd: begin
        ent_q.wsum <= sum_sat;
        ent_q.vol  <= vol_ext[VolW] ? {VolW{1'b1}} : vol_ext[VolW-1:0];
        if (ent_q.cnt != {CntW{1'b1}}) begin
          ent_q.cnt <= ent_q.cnt + 32'd1;
        end
      end
      StDivI: begin
        zero_q <= (ent_q.vol == '0);
        neg_q  <= ent_q.wsum[SumW-1];
        ovf_q  <= {8'd0, mag[SumW-1:PriceW]} >= ent_q.vol;
        rem_q  <= (VolW+1)'(mag[SumW-1:PriceW]);
        acc_q  <= {mag[PriceW-1:0], {(SumW-PriceW){1'b0}}};
        quo_q  <= '0;
        step_q <= '0;
      end
      StDiv: begin
        rem_q  <= div_ge ? (div_t - {1'b0, ent_q.vol}) : div_t;
        quo_q  <= {quo_q[PriceW-2:0], div_ge};
        acc_q  <= {acc_q[SumW-2:0], 1'b0};
        step_q <= step_q + 6'd1;
      end
      StFin: begin
        ent_q.avg <= avg_fin;
      end
      StOut: begin
        if (out_free) begin
          out_q.average_price <= ent_q.avg;
          out_q.total_volume  <= ent_q.vol;
          out_q.trade_count   <= ent_q.cnt;
          out_q.accepted      <= go_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/pwavg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pwavg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
